### sv/qapm_pkg.sv
// Shared types, constants and arithmetic helpers of the attitude PD mixer.
package qapm_pkg;

    // Default number of fractional bits of the internal fixed-point format
    localparam int FRAC_BITS_DEF = 16;

    // Register file geometry
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ROLL_KP       = 3'd0,
        REG_ROLL_KD_RATE  = 3'd1,
        REG_PITCH_KP      = 3'd2,
        REG_PITCH_KD_RATE = 3'd3,
        REG_FILTER_ALPHA  = 3'd4,
        REG_CORR_LIMIT    = 3'd5,
        REG_THROTTLE_MIN  = 3'd6,
        REG_THROTTLE_MAX  = 3'd7
    } cfg_reg_t;

    // Register reset values
    localparam logic [15:0] ROLL_KP_RST       = 16'd512;
    localparam logic [15:0] ROLL_KD_RATE_RST  = 16'd38400;
    localparam logic [15:0] PITCH_KP_RST      = 16'd512;
    localparam logic [15:0] PITCH_KD_RATE_RST = 16'd38400;
    localparam logic [15:0] FILTER_ALPHA_RST  = 16'd9830;
    localparam logic [7:0]  CORR_LIMIT_RST    = 8'd4;
    localparam logic [10:0] THROTTLE_MIN_RST  = 11'd100;
    localparam logic [10:0] THROTTLE_MAX_RST  = 11'd300;

    // Squared-rate weights in Q0.16 (0.03 and 0.01)
    localparam logic [11:0] K_X_SQ = 12'd1966;
    localparam logic [11:0] K_Y_SQ = 12'd655;

    // Input action codes
    localparam logic ACT_SAMPLE = 1'b0;
    localparam logic ACT_SET    = 1'b1;

    // Sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DONE
    } state_t;

    // Throttle clamp bounds handed to the motor stage
    typedef struct packed {
        logic [10:0] tmin;
        logic [10:0] tmax;
    } lim_t;

    // Divide by 2^s, rounding to nearest with ties away from zero
    function automatic logic signed [63:0] rshr(input logic signed [63:0] v,
                                                input int unsigned s);
        logic signed [63:0] half;
        half = 64'sd1 <<< (s - 1);
        if (v >= 0)
        begin
            return (v + half) >>> s;
        end
        return -((-v + half) >>> s);
    endfunction

    // Saturate to the signed 32-bit range
    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        if (v > 64'sd2147483647)
        begin
            return 32'sh7FFF_FFFF;
        end
        if (v < -64'sd2147483648)
        begin
            return 32'sh8000_0000;
        end
        return v[31:0];
    endfunction

    // DShot frame: throttle, telemetry bit 0, XOR checksum
    function automatic logic [15:0] dshot_frame(input logic [10:0] thr);
        logic [11:0] a;
        logic [3:0]  crc;
        a   = {thr, 1'b0};
        crc = a[3:0] ^ a[7:4] ^ a[11:8];
        return {a, crc};
    endfunction

endpackage

### sv/qapm_if.sv
// Stream interfaces for IMU/set items and motor result items.
interface qapm_in_if;
    logic               valid;
    logic               ready;
    logic               action;
    logic signed [15:0] accel_x;
    logic signed [15:0] accel_y;
    logic signed [15:0] gyro_x;
    logic signed [15:0] gyro_y;
    logic [10:0]        throttle_value;

    modport source (output valid, action, accel_x, accel_y, gyro_x, gyro_y,
                    throttle_value, input ready);
    modport sink   (input valid, action, accel_x, accel_y, gyro_x, gyro_y,
                    throttle_value, output ready);
endinterface

interface qapm_out_if;
    logic        valid;
    logic        ready;
    logic [10:0] motor_rear_left;
    logic [10:0] motor_front_left;
    logic [10:0] motor_rear_right;
    logic [10:0] motor_front_right;
    logic [15:0] frame_rear_left;
    logic [15:0] frame_front_left;
    logic [15:0] frame_rear_right;
    logic [15:0] frame_front_right;

    modport source (output valid, motor_rear_left, motor_front_left, motor_rear_right,
                    motor_front_right, frame_rear_left, frame_front_left,
                    frame_rear_right, frame_front_right, input ready);
    modport sink   (input valid, motor_rear_left, motor_front_left, motor_rear_right,
                    motor_front_right, frame_rear_left, frame_front_left,
                    frame_rear_right, frame_front_right, output ready);
endinterface

### sv/qapm_mul.sv
// Shared registered signed multiplier used by the sequencer.
module qapm_mul #(
    parameter int A_W = 21,
    parameter int B_W = 33
) (
    input  logic                       clk,
    input  logic signed [A_W-1:0]      a,
    input  logic signed [B_W-1:0]      b,
    output logic signed [A_W+B_W-1:0]  p
);

    logic signed [A_W+B_W-1:0] p_reg;

    // Register the product for the next step
    always_ff @(posedge clk)
    begin
        p_reg <= a * b;
    end

    assign p = p_reg;

endmodule

### sv/qapm_motor.sv
// Motor mix stage: add correction to base, round to whole throttle, clamp.
module qapm_motor #(
    parameter int FRAC_BITS = qapm_pkg::FRAC_BITS_DEF
) (
    input  logic [10:0]                base,
    input  logic signed [FRAC_BITS+17:0] delta,
    input  qapm_pkg::lim_t             lim,
    output logic [10:0]                thr
);

    localparam int SH = FRAC_BITS + 8;

    logic signed [63:0] m;
    logic signed [63:0] v;
    logic signed [63:0] vmax;
    logic signed [63:0] vmin;

    // Round the mix, apply upper bound first, then lower bound
    always_comb
    begin
        m    = ($signed({53'd0, base}) <<< SH) + 64'(delta);
        v    = qapm_pkg::rshr(m, SH);
        vmax = $signed({53'd0, lim.tmax});
        vmin = $signed({53'd0, lim.tmin});
        if (v > vmax)
        begin
            v = vmax;
        end
        if (v < vmin)
        begin
            v = vmin;
        end
        thr = v[10:0];
    end

endmodule

### sv/quad_attitude_pd_mixer.sv
// Attitude PD stabilizer with X-frame motor mixer and DShot frame builder.
// An IMU item runs 19 steps: 14 multiplies issued one per cycle to one shared registered
// multiplier, one step to take the last product, then four motor mix steps.
// The result register loads in the done state once the previous result is taken or absent;
// the next item is taken only after that, back in idle.
// A set item loads the bases at its transfer and starts no sequence. Reset is asynchronous,
// active low: registers at defaults, filters and bases zero.
module quad_attitude_pd_mixer #(
    parameter int FRAC_BITS = qapm_pkg::FRAC_BITS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    qapm_in_if.sink                             sample,
    qapm_out_if.source                          result,
    input  logic                                cfg_we,
    input  logic [qapm_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [qapm_pkg::CFG_DATA_W-1:0]     cfg_data
);

    // Fixed-point widths derived from the fraction size
    localparam int RATE_W = FRAC_BITS + 4;
    localparam int ACC_W  = FRAC_BITS + 6;
    localparam int T_W    = FRAC_BITS + 6;
    localparam int C_W    = FRAC_BITS + 7;
    localparam int CORR_W = FRAC_BITS + 17;
    localparam int D_W    = FRAC_BITS + 18;
    localparam int A_W    = (FRAC_BITS + 5 > 17) ? FRAC_BITS + 5 : 17;
    localparam int B_W    = 33;
    localparam int P_W    = A_W + B_W;
    localparam int STEP_W = 5;

    localparam longint unsigned ACC_K =
        ((64'd980665 << FRAC_BITS) + 64'd50000) / 64'd100000;
    localparam longint unsigned GYRO_K =
        ((64'd1331 << (FRAC_BITS + 16)) + 64'd5000000) / 64'd10000000;

    // Sequencer step numbers
    localparam logic [STEP_W-1:0] S_GY   = 5'd0;
    localparam logic [STEP_W-1:0] S_GX   = 5'd1;
    localparam logic [STEP_W-1:0] S_AX   = 5'd2;
    localparam logic [STEP_W-1:0] S_RY2  = 5'd3;
    localparam logic [STEP_W-1:0] S_AY   = 5'd4;
    localparam logic [STEP_W-1:0] S_RX2  = 5'd5;
    localparam logic [STEP_W-1:0] S_TY   = 5'd6;
    localparam logic [STEP_W-1:0] S_TX   = 5'd7;
    localparam logic [STEP_W-1:0] S_FR   = 5'd8;
    localparam logic [STEP_W-1:0] S_FP   = 5'd9;
    localparam logic [STEP_W-1:0] S_KPR  = 5'd10;
    localparam logic [STEP_W-1:0] S_KDR  = 5'd11;
    localparam logic [STEP_W-1:0] S_KPP  = 5'd12;
    localparam logic [STEP_W-1:0] S_KDP  = 5'd13;
    localparam logic [STEP_W-1:0] S_CP   = 5'd14;
    localparam logic [STEP_W-1:0] S_MIX0 = 5'd15;
    localparam logic [STEP_W-1:0] S_LAST = 5'd18;

    // Configuration registers
    logic [15:0] roll_kp_reg;
    logic [15:0] roll_kd_reg;
    logic [15:0] pitch_kp_reg;
    logic [15:0] pitch_kd_reg;
    logic [15:0] alpha_reg;
    logic [7:0]  limit_reg;
    logic [10:0] tmin_reg;
    logic [10:0] tmax_reg;

    // Control state
    qapm_pkg::state_t  state_reg;
    qapm_pkg::state_t  state_next;
    logic [STEP_W-1:0] step_reg;
    logic [STEP_W-1:0] step_next;
    logic              out_valid_reg;
    logic              out_valid_next;

    // Datapath state
    logic signed [15:0]       ax_reg, ay_reg, gx_reg, gy_reg;
    logic signed [RATE_W-1:0] rate_x_reg, rate_y_reg;
    logic signed [ACC_W-1:0]  acc_x_reg, acc_y_reg;
    logic signed [T_W-1:0]    t_x_reg, t_y_reg;
    logic signed [C_W-1:0]    c_x_reg, c_y_reg;
    logic signed [31:0]       filt_r_reg, filt_p_reg;
    logic signed [31:0]       old_r_reg, old_p_reg;
    logic signed [P_W-1:0]    kpt_reg;
    logic signed [CORR_W-1:0] corr_r_reg, corr_p_reg;
    logic [10:0]              base_reg [4];
    logic [10:0]              mot_reg [4];
    logic [15:0]              frm_reg [4];

    // Shared unit and helpers
    logic signed [A_W-1:0] mul_a;
    logic signed [B_W-1:0] mul_b;
    logic signed [P_W-1:0] mul_p;
    logic signed [63:0]    a64, b64, p64;
    logic signed [63:0]    r16, r14, rf, c64, f64, s64, lim64, d64;
    logic signed [31:0]    filt_new;
    logic signed [CORR_W-1:0] corr_new;
    logic [1:0]            mix_idx;
    logic signed [D_W-1:0] mix_delta;
    logic [10:0]           mix_thr;
    qapm_pkg::lim_t        lim;
    logic                  in_fire;
    logic                  out_free;

    assign in_fire  = sample.valid && sample.ready;
    assign out_free = !out_valid_reg || result.ready;
    assign lim      = '{tmin: tmin_reg, tmax: tmax_reg};
    assign mix_idx  = 2'(step_reg - S_MIX0);

    // Write configuration registers; unknown indexes fall through
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            roll_kp_reg  <= qapm_pkg::ROLL_KP_RST;
            roll_kd_reg  <= qapm_pkg::ROLL_KD_RATE_RST;
            pitch_kp_reg <= qapm_pkg::PITCH_KP_RST;
            pitch_kd_reg <= qapm_pkg::PITCH_KD_RATE_RST;
            alpha_reg    <= qapm_pkg::FILTER_ALPHA_RST;
            limit_reg    <= qapm_pkg::CORR_LIMIT_RST;
            tmin_reg     <= qapm_pkg::THROTTLE_MIN_RST;
            tmax_reg     <= qapm_pkg::THROTTLE_MAX_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                qapm_pkg::REG_ROLL_KP:       roll_kp_reg  <= cfg_data;
                qapm_pkg::REG_ROLL_KD_RATE:  roll_kd_reg  <= cfg_data;
                qapm_pkg::REG_PITCH_KP:      pitch_kp_reg <= cfg_data;
                qapm_pkg::REG_PITCH_KD_RATE: pitch_kd_reg <= cfg_data;
                qapm_pkg::REG_FILTER_ALPHA:  alpha_reg    <= cfg_data;
                qapm_pkg::REG_CORR_LIMIT:    limit_reg    <= cfg_data[7:0];
                qapm_pkg::REG_THROTTLE_MIN:  tmin_reg     <= cfg_data[10:0];
                qapm_pkg::REG_THROTTLE_MAX:  tmax_reg     <= cfg_data[10:0];
                default:                     ;
            endcase
        end
    end

    // Next state of the sequencer
    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        case (state_reg)
            qapm_pkg::ST_IDLE:
            begin
                step_next = '0;
                if (in_fire && sample.action == qapm_pkg::ACT_SAMPLE)
                begin
                    state_next = qapm_pkg::ST_RUN;
                end
            end
            qapm_pkg::ST_RUN:
            begin
                step_next = step_reg + 1'b1;
                if (step_reg == S_LAST)
                begin
                    state_next = qapm_pkg::ST_DONE;
                end
            end
            qapm_pkg::ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = qapm_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = qapm_pkg::ST_IDLE;
            end
        endcase
    end

    // Handshake outputs and result valid
    always_comb
    begin
        sample.ready   = (state_reg == qapm_pkg::ST_IDLE);
        out_valid_next = out_valid_reg && !result.ready;
        if (state_reg == qapm_pkg::ST_DONE && out_free)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= qapm_pkg::ST_IDLE;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Select multiplier operands for the current step
    always_comb
    begin
        a64 = '0;
        b64 = '0;
        case (step_reg)
            S_GY:  begin a64 = $signed(GYRO_K); b64 = 64'(gy_reg); end
            S_GX:  begin a64 = $signed(GYRO_K); b64 = 64'(gx_reg); end
            S_AX:  begin a64 = $signed(ACC_K);  b64 = 64'(ax_reg); end
            S_RY2: begin a64 = 64'(rate_y_reg); b64 = 64'(rate_y_reg); end
            S_AY:  begin a64 = $signed(ACC_K);  b64 = 64'(ay_reg); end
            S_RX2: begin a64 = 64'(rate_x_reg); b64 = 64'(rate_x_reg); end
            S_TY:  begin a64 = $signed({52'd0, qapm_pkg::K_X_SQ}); b64 = 64'(t_y_reg); end
            S_TX:  begin a64 = $signed({52'd0, qapm_pkg::K_Y_SQ}); b64 = 64'(t_x_reg); end
            S_FR:
            begin
                a64 = $signed({48'd0, alpha_reg});
                b64 = 64'(c_x_reg) - 64'(filt_r_reg);
            end
            S_FP:
            begin
                a64 = $signed({48'd0, alpha_reg});
                b64 = 64'(c_y_reg) - 64'(filt_p_reg);
            end
            S_KPR: begin a64 = $signed({48'd0, roll_kp_reg});  b64 = 64'(filt_r_reg); end
            S_KDR:
            begin
                a64 = $signed({48'd0, roll_kd_reg});
                b64 = 64'(filt_r_reg) - 64'(old_r_reg);
            end
            S_KPP: begin a64 = $signed({48'd0, pitch_kp_reg}); b64 = 64'(filt_p_reg); end
            S_KDP:
            begin
                a64 = $signed({48'd0, pitch_kd_reg});
                b64 = 64'(filt_p_reg) - 64'(old_p_reg);
            end
            default: ;
        endcase
        mul_a = a64[A_W-1:0];
        mul_b = b64[B_W-1:0];
    end

    qapm_mul #(
        .A_W(A_W),
        .B_W(B_W)
    ) u_mul (
        .clk(clk),
        .a  (mul_a),
        .b  (mul_b),
        .p  (mul_p)
    );

    // Post-process the product of the previous step
    always_comb
    begin
        p64   = 64'(mul_p);
        r16   = qapm_pkg::rshr(p64, 16);
        r14   = qapm_pkg::rshr(p64, 14);
        rf    = qapm_pkg::rshr(p64, FRAC_BITS);
        c64   = (step_reg == S_TX) ? 64'(acc_x_reg) - r16 : 64'(acc_y_reg) - r16;
        f64   = (step_reg == S_FP) ? 64'(filt_r_reg) : 64'(filt_p_reg);
        filt_new = qapm_pkg::sat32(f64 + r16);
        lim64 = $signed({56'd0, limit_reg}) <<< (FRAC_BITS + 8);
        s64   = 64'(kpt_reg) + p64;
        if (s64 > lim64)
        begin
            s64 = lim64;
        end
        if (s64 < -lim64)
        begin
            s64 = -lim64;
        end
        corr_new = s64[CORR_W-1:0];
    end

    // Pick the correction sum for the motor being mixed
    always_comb
    begin
        case (mix_idx)
            2'd0:    d64 = 64'(corr_r_reg) - 64'(corr_p_reg);
            2'd1:    d64 = -64'(corr_r_reg) - 64'(corr_p_reg);
            2'd2:    d64 = 64'(corr_r_reg) + 64'(corr_p_reg);
            default: d64 = -64'(corr_r_reg) + 64'(corr_p_reg);
        endcase
        mix_delta = d64[D_W-1:0];
    end

    qapm_motor #(
        .FRAC_BITS(FRAC_BITS)
    ) u_motor (
        .base (base_reg[mix_idx]),
        .delta(mix_delta),
        .lim  (lim),
        .thr  (mix_thr)
    );

    // Filter and base state: cleared by reset, updated by set items and by the sequence
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            filt_r_reg <= '0;
            filt_p_reg <= '0;
            for (int i = 0; i < 4; i++)
            begin
                base_reg[i] <= '0;
            end
        end
        else if (in_fire && sample.action == qapm_pkg::ACT_SET)
        begin
            for (int i = 0; i < 4; i++)
            begin
                base_reg[i] <= sample.throttle_value;
            end
        end
        else if (state_reg == qapm_pkg::ST_RUN)
        begin
            if (step_reg == S_FP)
            begin
                filt_r_reg <= filt_new;
            end
            if (step_reg == S_KPR)
            begin
                filt_p_reg <= filt_new;
            end
            if (step_reg >= S_MIX0)
            begin
                base_reg[mix_idx] <= mix_thr;
            end
        end
    end

    // Latch the item and hold intermediate results
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            ax_reg <= sample.accel_x;
            ay_reg <= sample.accel_y;
            gx_reg <= sample.gyro_x;
            gy_reg <= sample.gyro_y;
        end
        if (state_reg == qapm_pkg::ST_RUN)
        begin
            case (step_reg)
                S_GX:  rate_y_reg <= r16[RATE_W-1:0];
                S_AX:  rate_x_reg <= r16[RATE_W-1:0];
                S_RY2: acc_x_reg  <= r14[ACC_W-1:0];
                S_AY:  t_y_reg    <= rf[T_W-1:0];
                S_RX2: acc_y_reg  <= r14[ACC_W-1:0];
                S_TY:  t_x_reg    <= rf[T_W-1:0];
                S_TX:  c_x_reg    <= c64[C_W-1:0];
                S_FR:  c_y_reg    <= c64[C_W-1:0];
                S_FP:  old_r_reg  <= filt_r_reg;
                S_KPR: old_p_reg  <= filt_p_reg;
                S_KDR: kpt_reg    <= mul_p;
                S_KPP: corr_r_reg <= corr_new;
                S_KDP: kpt_reg    <= mul_p;
                S_CP:  corr_p_reg <= corr_new;
                default: ;
            endcase
        end
        // Load the result register from the new bases
        if (state_reg == qapm_pkg::ST_DONE && out_free)
        begin
            for (int i = 0; i < 4; i++)
            begin
                mot_reg[i] <= base_reg[i];
                frm_reg[i] <= qapm_pkg::dshot_frame(base_reg[i]);
            end
        end
    end

    assign result.valid             = out_valid_reg;
    assign result.motor_rear_left   = mot_reg[0];
    assign result.motor_front_left  = mot_reg[1];
    assign result.motor_rear_right  = mot_reg[2];
    assign result.motor_front_right = mot_reg[3];
    assign result.frame_rear_left   = frm_reg[0];
    assign result.frame_front_left  = frm_reg[1];
    assign result.frame_rear_right  = frm_reg[2];
    assign result.frame_front_right = frm_reg[3];

`ifndef NO_ASSERTIONS
    // No new item while a sample is being worked on
    a_busy_not_ready: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != qapm_pkg::ST_IDLE) |-> !sample.ready)
        else $error("input ready while sequencer busy");

    // A result appears only when a finished sample is loaded
    a_valid_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result.valid) |-> $past(state_reg) == qapm_pkg::ST_DONE)
        else $error("result valid without finished sample");

    // Step counter stays within the schedule while running
    a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == qapm_pkg::ST_RUN) |-> (step_reg <= S_LAST))
        else $error("step counter out of range");

    // A set item completes at acceptance and starts no sequence
    a_set_stays_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && sample.action == qapm_pkg::ACT_SET) |=>
            (state_reg == qapm_pkg::ST_IDLE))
        else $error("set item started a sequence");
`endif

endmodule

### test/qapm_checker.sv
// Scoreboard for the attitude PD mixer: predicts motor results and compares transfers.
module qapm_checker
    import qapm_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    qapm_in_if                    sample,
    qapm_out_if                   result,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output int                    fail_count,
    output int                    pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int F = FRAC_BITS_DEF;
    localparam longint ACC_SCALE  = ((64'd980665 << F) + 64'd50000) / 64'd100000;
    localparam longint GYRO_SCALE = ((64'd1331 << (F + 16)) + 64'd5000000) / 64'd10000000;

    typedef struct packed {
        logic [3:0][10:0] motor;
        logic [3:0][15:0] frame;
    } motor_set_t;

    // Shadow registers and state of the block
    logic [15:0] kp_roll, kd_roll, kp_pitch, kd_pitch, alpha;
    logic [7:0]  corr_lim;
    logic [10:0] thr_min, thr_max;
    logic signed [31:0] filt_roll, filt_pitch;
    logic [3:0][10:0]   bases;
    motor_set_t expected_motors[$];

    assign pending = expected_motors.size();

    // Divide by 2^s, nearest, ties away from zero
    function automatic longint round_shift(input longint v, input int s);
        longint mag;
        mag = (v < 0) ? -v : v;
        mag = (mag + (64'sd1 <<< (s - 1))) >>> s;
        return (v < 0) ? -mag : mag;
    endfunction

    function automatic logic signed [31:0] clip32(input longint v);
        if (v > 64'sd2147483647)
        begin
            return 32'sh7FFF_FFFF;
        end
        if (v < -64'sd2147483648)
        begin
            return 32'sh8000_0000;
        end
        return v[31:0];
    endfunction

    function automatic longint pd_term(input longint now, input longint old,
                                       input logic [15:0] kp, input logic [15:0] kd);
        longint lim;
        longint c;
        lim = longint'(corr_lim) <<< (F + 8);
        c = longint'(kp) * now + longint'(kd) * (now - old);
        if (c > lim)
        begin
            c = lim;
        end
        if (c < -lim)
        begin
            c = -lim;
        end
        return c;
    endfunction

    function automatic logic [10:0] mix_motor(input logic [10:0] base, input longint delta);
        longint v;
        v = round_shift((longint'(base) <<< (F + 8)) + delta, F + 8);
        if (v > longint'(thr_max))
        begin
            v = thr_max;
        end
        if (v < longint'(thr_min))
        begin
            v = thr_min;
        end
        return v[10:0];
    endfunction

    function automatic logic [15:0] build_frame(input logic [10:0] thr);
        logic [11:0] a;
        logic [3:0]  sum;
        a   = {thr, 1'b0};
        sum = 4'(a ^ (a >> 4) ^ (a >> 8));
        return {a, sum};
    endfunction

    // Advance the predicted attitude loop by one IMU sample
    task automatic predict_sample(input logic signed [15:0] ax, input logic signed [15:0] ay,
                                  input logic signed [15:0] gx, input logic signed [15:0] gy);
        longint acc_x, acc_y, rate_x, rate_y, cx, cy, corr_r, corr_p;
        logic signed [31:0] new_r, new_p;
        logic signed [63:0] deltas[4];
        motor_set_t m;
        acc_x  = round_shift(longint'(ax) * ACC_SCALE, 14);
        acc_y  = round_shift(longint'(ay) * ACC_SCALE, 14);
        rate_x = round_shift(longint'(gx) * GYRO_SCALE, 16);
        rate_y = round_shift(longint'(gy) * GYRO_SCALE, 16);
        cx = acc_x - round_shift(round_shift(rate_y * rate_y, F) * longint'(K_X_SQ), 16);
        cy = acc_y - round_shift(round_shift(rate_x * rate_x, F) * longint'(K_Y_SQ), 16);
        new_r = clip32(longint'(filt_roll)
                       + round_shift(longint'(alpha) * (cx - longint'(filt_roll)), 16));
        new_p = clip32(longint'(filt_pitch)
                       + round_shift(longint'(alpha) * (cy - longint'(filt_pitch)), 16));
        corr_r = pd_term(new_r, filt_roll, kp_roll, kd_roll);
        corr_p = pd_term(new_p, filt_pitch, kp_pitch, kd_pitch);
        filt_roll  = new_r;
        filt_pitch = new_p;
        deltas[0] = corr_r - corr_p;
        deltas[1] = -corr_r - corr_p;
        deltas[2] = corr_r + corr_p;
        deltas[3] = -corr_r + corr_p;
        for (int i = 0; i < 4; i++)
        begin
            bases[i]   = mix_motor(bases[i], deltas[i]);
            m.motor[i] = bases[i];
            m.frame[i] = build_frame(bases[i]);
        end
        expected_motors.push_back(m);
    endtask

    // Track registers, predict on input transfers, compare on output transfers
    always @(posedge clk or negedge rst_n)
    begin
        motor_set_t got;
        motor_set_t want;
        if (!rst_n)
        begin
            kp_roll    = ROLL_KP_RST;
            kd_roll    = ROLL_KD_RATE_RST;
            kp_pitch   = PITCH_KP_RST;
            kd_pitch   = PITCH_KD_RATE_RST;
            alpha      = FILTER_ALPHA_RST;
            corr_lim   = CORR_LIMIT_RST;
            thr_min    = THROTTLE_MIN_RST;
            thr_max    = THROTTLE_MAX_RST;
            filt_roll  = '0;
            filt_pitch = '0;
            bases      = '0;
            fail_count = 0;
            expected_motors.delete();
        end
        else
        begin
            if (result.valid && result.ready)
            begin
                got.motor = {result.motor_front_right, result.motor_rear_right,
                             result.motor_front_left, result.motor_rear_left};
                got.frame = {result.frame_front_right, result.frame_rear_right,
                             result.frame_front_left, result.frame_rear_left};
                if (expected_motors.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                    begin
                        $display("unexpected result transfer: motors %p", got.motor);
                    end
                end
                else
                begin
                    want = expected_motors.pop_front();
                    for (int i = 0; i < 4; i++)
                    begin
                        if (got.motor[i] !== want.motor[i] || got.frame[i] !== want.frame[i])
                        begin
                            fail_count++;
                            if (fail_count <= 10)
                            begin
                                $display("motor %0d mismatch: expected %0d/%h got %0d/%h",
                                         i, want.motor[i], want.frame[i],
                                         got.motor[i], got.frame[i]);
                            end
                        end
                    end
                end
            end
            if (sample.valid && sample.ready)
            begin
                if (sample.action == ACT_SET)
                begin
                    bases = {4{sample.throttle_value}};
                end
                else
                begin
                    predict_sample(sample.accel_x, sample.accel_y,
                                   sample.gyro_x, sample.gyro_y);
                end
            end
            if (cfg_we)
            begin
                case (cfg_reg_t'(cfg_index))
                    REG_ROLL_KP:       kp_roll  = cfg_data;
                    REG_ROLL_KD_RATE:  kd_roll  = cfg_data;
                    REG_PITCH_KP:      kp_pitch = cfg_data;
                    REG_PITCH_KD_RATE: kd_pitch = cfg_data;
                    REG_FILTER_ALPHA:  alpha    = cfg_data;
                    REG_CORR_LIMIT:    corr_lim = cfg_data[7:0];
                    REG_THROTTLE_MIN:  thr_min  = cfg_data[10:0];
                    REG_THROTTLE_MAX:  thr_max  = cfg_data[10:0];
                    default:           ;
                endcase
            end
        end
    end
endmodule

### test/tb.sv
// Top of the attitude PD mixer regression: stimulus, register phases and verdict.
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import qapm_pkg::*;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    int                    fail_count;
    int                    pending;
    int                    burst_left;
    int                    stall_mode;

    qapm_in_if  sample_ch();
    qapm_out_if result_ch();

    quad_attitude_pd_mixer u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .sample    (sample_ch),
        .result    (result_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    qapm_checker u_check (
        .clk        (clk),
        .rst_n      (rst_n),
        .sample     (sample_ch),
        .result     (result_ch),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .fail_count (fail_count),
        .pending    (pending)
    );

    always
    begin
        clk = 1'b1;
        #1;
        clk = 1'b0;
        #1;
    end

    // Stall the result channel; the pattern changes at random
    always @(negedge clk)
    begin
        if ($urandom_range(63) == 0)
        begin
            stall_mode <= $urandom_range(3);
        end
        case (stall_mode)
            0:       result_ch.ready <= 1'b1;
            1:       result_ch.ready <= ($urandom_range(1) == 0);
            2:       result_ch.ready <= ($urandom_range(7) == 0);
            default: result_ch.ready <= ($urandom_range(7) != 0);
        endcase
    end

    // Pick a 16-bit field: extremes and zero often, sometimes -1000 to 1000, otherwise anything
    function automatic logic signed [15:0] pick_raw();
        case ($urandom_range(7))
            0:       return 16'sh8000;
            1:       return 16'sh7FFF;
            2:       return 16'sh0000;
            3:       return 16'(int'($urandom_range(2000)) - 1000);
            default: return 16'($urandom);
        endcase
    endfunction

    // Move one item; the sender runs in bursts with gaps between them
    task automatic send_item(input logic act, input logic signed [15:0] ax,
                             input logic signed [15:0] ay, input logic signed [15:0] gx,
                             input logic signed [15:0] gy, input logic [10:0] thr);
        int gap;
        if (burst_left == 0)
        begin
            gap = $urandom_range(8);
            if (gap != 0)
            begin
                sample_ch.valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            burst_left = $urandom_range(1, 20);
        end
        burst_left--;
        sample_ch.valid          <= 1'b1;
        sample_ch.action         <= act;
        sample_ch.accel_x        <= ax;
        sample_ch.accel_y        <= ay;
        sample_ch.gyro_x         <= gx;
        sample_ch.gyro_y         <= gy;
        sample_ch.throttle_value <= thr;
        do
        begin
            @(posedge clk);
        end
        while (!sample_ch.ready);
        @(negedge clk);
    endtask

    task automatic send_random();
        if ($urandom_range(6) == 0)
        begin
            send_item(ACT_SET, pick_raw(), pick_raw(), pick_raw(), pick_raw(),
                      11'($urandom));
        end
        else
        begin
            send_item(ACT_SAMPLE, pick_raw(), pick_raw(), pick_raw(), pick_raw(),
                      11'($urandom));
        end
    endtask

    // Drain the block, then write one register
    task automatic write_reg(input cfg_reg_t idx, input logic [15:0] val);
        sample_ch.valid <= 1'b0;
        while (pending != 0)
        begin
            @(negedge clk);
        end
        repeat (25) @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic program_all(input logic [15:0] kpr, input logic [15:0] kdr,
                               input logic [15:0] kpp, input logic [15:0] kdp,
                               input logic [15:0] alp, input logic [7:0] lim,
                               input logic [10:0] tmin, input logic [10:0] tmax);
        write_reg(REG_ROLL_KP, kpr);
        write_reg(REG_ROLL_KD_RATE, kdr);
        write_reg(REG_PITCH_KP, kpp);
        write_reg(REG_PITCH_KD_RATE, kdp);
        write_reg(REG_FILTER_ALPHA, alp);
        write_reg(REG_CORR_LIMIT, 16'(lim));
        write_reg(REG_THROTTLE_MIN, 16'(tmin));
        write_reg(REG_THROTTLE_MAX, 16'(tmax));
    endtask

    initial
    begin
        #2ms;
        $display("quad_attitude_pd_mixer regression: fail");
        $finish;
    end

    initial
    begin
        rst_n                    = 1'b0;
        cfg_we                   = 1'b0;
        cfg_index                = '0;
        cfg_data                 = '0;
        stall_mode               = 0;
        burst_left               = 0;
        result_ch.ready          = 1'b1;
        sample_ch.valid          = 1'b0;
        sample_ch.action         = ACT_SAMPLE;
        sample_ch.accel_x        = '0;
        sample_ch.accel_y        = '0;
        sample_ch.gyro_x         = '0;
        sample_ch.gyro_y         = '0;
        sample_ch.throttle_value = '0;
        repeat (5) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed: defaults, sample before any set, set extremes, field extremes
        send_item(ACT_SAMPLE, 16'sh0000, 16'sh0000, 16'sh0000, 16'sh0000, 11'd0);
        send_item(ACT_SET, 16'sh0000, 16'sh0000, 16'sh0000, 16'sh0000, 11'd0);
        send_item(ACT_SAMPLE, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 11'd0);
        send_item(ACT_SET, 16'sh0000, 16'sh0000, 16'sh0000, 16'sh0000, 11'd2047);
        send_item(ACT_SAMPLE, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 11'd2047);
        send_item(ACT_SAMPLE, 16'sh8000, 16'sh7FFF, 16'sh7FFF, 16'sh8000, 11'd0);
        send_item(ACT_SET, 16'sh0000, 16'sh0000, 16'sh0000, 16'sh0000, 11'd200);
        send_item(ACT_SAMPLE, 16'sh7FFF, 16'sh8000, 16'sh8000, 16'sh7FFF, 11'd0);
        send_item(ACT_SAMPLE, 16'sh0000, 16'sh0000, 16'sh0000, 16'sh0000, 11'd0);

        // Negative mix toward zero base with wide limits, then min above max
        program_all(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 8'd255, 11'd0, 11'd2047);
        send_item(ACT_SET, 16'sh0000, 16'sh0000, 16'sh0000, 16'sh0000, 11'd1);
        send_item(ACT_SAMPLE, 16'sh7FFF, 16'sh7FFF, 16'sh0000, 16'sh0000, 11'd0);
        send_item(ACT_SAMPLE, 16'sh8000, 16'sh8000, 16'sh0000, 16'sh0000, 11'd0);
        program_all(16'd512, 16'd38400, 16'd512, 16'd38400, 16'd9830, 8'd4, 11'd400, 11'd300);
        send_item(ACT_SAMPLE, 16'sh1000, 16'shF000, 16'sh0100, 16'sh0200, 11'd0);
        send_item(ACT_SAMPLE, 16'shF000, 16'sh1000, 16'sh0200, 16'sh0100, 11'd0);

        // Random phases under varied settings, extremes among them
        for (int phase = 0; phase < 7; phase++)
        begin
            case (phase)
                0: program_all(16'd512, 16'd38400, 16'd512, 16'd38400, 16'd9830,
                               8'd4, 11'd100, 11'd300);
                1: program_all(16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 8'd0, 11'd0, 11'd0);
                2: program_all(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                               8'd255, 11'd0, 11'd2047);
                3: program_all(16'hFFFF, 16'd0, 16'd0, 16'hFFFF, 16'd1, 8'd255,
                               11'd2047, 11'd2047);
                4: program_all(16'd1200, 16'd9000, 16'd300, 16'd50000, 16'd32768,
                               8'd40, 11'd1500, 11'd200);
                default: program_all(16'($urandom), 16'($urandom), 16'($urandom),
                                     16'($urandom), 16'($urandom), 8'($urandom),
                                     11'($urandom_range(1000)),
                                     11'($urandom_range(1000, 2047)));
            endcase
            repeat (125) send_random();
        end

        // Drain and settle, then give the verdict
        sample_ch.valid <= 1'b0;
        while (pending != 0)
        begin
            @(negedge clk);
        end
        repeat (30) @(negedge clk);
        if (fail_count == 0)
        begin
            $display("quad_attitude_pd_mixer regression: pass");
        end
        else
        begin
            $display("quad_attitude_pd_mixer regression: fail");
        end
        $finish;
    end
endmodule
